// ----- sv/conditional_alu_with_flags_core_macros.svh -----
// Assertion macros for the conditional ALU checker.
// Included by the checker file only.
`ifndef CONDITIONAL_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define CONDITIONAL_ALU_WITH_FLAGS_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CAF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/caf_pkg.sv -----
// Shared types and constants for the conditional ALU.
// No dependencies.
package caf_pkg;

  typedef enum logic [3:0] {
    CMD_HALT = 4'd0, CMD_INT = 4'd1, CMD_MOV = 4'd2, CMD_ADD = 4'd3,
    CMD_SUB = 4'd4, CMD_MUL = 4'd5, CMD_DIV = 4'd6, CMD_IDIV = 4'd7,
    CMD_AND = 4'd8, CMD_OR = 4'd9, CMD_XOR = 4'd10, CMD_CMP = 4'd11,
    CMD_TEST = 4'd12, CMD_ILL13 = 4'd13, CMD_ILL14 = 4'd14, CMD_ILL15 = 4'd15
  } cmd_e;

  typedef enum logic [3:0] {
    CC_ALWAYS = 4'd0, CC_Z = 4'd1, CC_NZ = 4'd2, CC_C = 4'd3, CC_NC = 4'd4,
    CC_O = 4'd5, CC_NO = 4'd6, CC_S = 4'd7, CC_NS = 4'd8, CC_A = 4'd9,
    CC_BE = 4'd10, CC_GT = 4'd11, CC_LE = 4'd12, CC_GE = 4'd13, CC_LT = 4'd14,
    CC_NEVER = 4'd15
  } cond_e;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_DEST = 2'd1;
  localparam logic [1:0] TGT_R0   = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_ILLOP = 2'd2;

  localparam logic [7:0] VEC_EXIT = 8'h80;
  localparam logic [7:0] VEC_DEC  = 8'h81;

  // flag bit positions
  localparam int FZ = 0;
  localparam int FC = 1;
  localparam int FO = 2;
  localparam int FS = 3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_FIN, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic exec;      // execute the operation or set up mul/div
    logic mul_step;  // accumulate one partial product
    logic mul_fin;   // form mul flags
    logic div_start;
    logic div_step;
    logic div_fin;
    logic out_load;  // copy result to output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic mul_last;
    logic div_last;
  } sts_t;

  function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
    logic z, c, o, s, r;
    z = f[FZ]; c = f[FC]; o = f[FO]; s = f[FS];
    unique case (cond_e'(cc))
      CC_ALWAYS: r = 1'b1;
      CC_Z:      r = z;
      CC_NZ:     r = !z;
      CC_C:      r = c;
      CC_NC:     r = !c;
      CC_O:      r = o;
      CC_NO:     r = !o;
      CC_S:      r = s;
      CC_NS:     r = !s;
      CC_A:      r = !c && !z;
      CC_BE:     r = c || z;
      CC_GT:     r = !z && (s == o);
      CC_LE:     r = z || (s != o);
      CC_GE:     r = s == o;
      CC_LT:     r = s != o;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/caf_ctrl.sv -----
// Controller state machine for the conditional ALU.
// Depends on caf_pkg.
module caf_ctrl import caf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.is_mul) state_d = ST_MUL;
        else if (sts_i.is_div) state_d = ST_DIV;
        else state_d = ST_OUT;
      end
      ST_MUL: if (sts_i.mul_last) state_d = ST_FIN;
      ST_DIV: if (sts_i.div_last) state_d = ST_FIN;
      ST_FIN: state_d = ST_OUT;
      ST_OUT: if (!ovalid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: ctl_o.load = in_valid_i;
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        ctl_o.div_start = sts_i.is_div;
      end
      ST_MUL: ctl_o.mul_step = 1'b1;
      ST_DIV: ctl_o.div_step = 1'b1;
      ST_FIN: begin
        ctl_o.mul_fin = sts_i.is_mul;
        ctl_o.div_fin = sts_i.is_div;
      end
      ST_OUT: ctl_o.out_load = !ovalid_q || !out_stall_i;
      default: ctl_o = '0;
    endcase
  end

  // output valid flag
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (ctl_o.out_load) ovalid_d = 1'b1;
  end

  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ----- sv/caf_dp.sv -----
// Datapath for the conditional ALU: operands, flags, multiplier, divider.
// Depends on caf_pkg.
module caf_dp import caf_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  logic [3:0]  cmd_i,
  input  logic [3:0]  cond_code_i,
  input  logic [63:0] dest_value_i,
  input  logic [63:0] src_value_i,
  output logic [1:0]  write_target_o,
  output logic [63:0] result_value_o,
  output logic [3:0]  flags_out_o,
  output logic [1:0]  error_code_o,
  output logic        halt_request_o,
  output logic        exit_request_o
);

  localparam int W     = DATA_WIDTH;
  localparam int HW    = (W + 1) / 2;       // multiplier chunk
  localparam int CW    = $clog2(W + 1);
  localparam int MSTEPS = 4;

  typedef logic [W-1:0] word_t;

  logic [3:0] cmd_q;
  logic [3:0] cc_q;
  word_t      a_q, b_q;
  logic [3:0] flags_q, flags_d;
  logic       go_q;

  // result staging
  logic [1:0] tgt_q, tgt_d;
  word_t      res_q, res_d;
  logic [1:0] err_q, err_d;
  logic       halt_q, halt_d, ex_q, ex_d;

  // multiplier: two products (raw and magnitudes), 4 partial steps each
  logic [1:0]   mstep_q;
  logic [2*W-1:0] pr_q, pm_q;
  word_t        ma_q, mb_q;

  // divider
  logic [CW-1:0] dcnt_q;
  word_t         dq_q, dr_q, dd_q, dv_q;
  logic          dneg_q;

  logic holds;
  assign holds = cond_holds(cc_q, flags_q);

  function automatic word_t magn(input word_t v);
    return v[W-1] ? word_t'(-v) : v;
  endfunction

  assign sts_o.is_mul   = go_q && (cmd_e'(cmd_q) == CMD_MUL);
  assign sts_o.is_div   = go_q && (cmd_q == CMD_DIV || cmd_q == CMD_IDIV) && (b_q != '0);
  assign sts_o.mul_last = (mstep_q == 2'(MSTEPS - 1));
  assign sts_o.div_last = (dcnt_q == CW'(1));

  // capture item
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      cc_q  <= cond_code_i;
      a_q   <= dest_value_i[W-1:0];
      b_q   <= src_value_i[W-1:0];
    end
  end

  // go_q: condition result, registered at load from the incoming condition code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) go_q <= 1'b0;
    else if (ctl_i.load) go_q <= cond_holds(cond_code_i, flags_q);
  end

  // simple operations and flag updates
  logic [W:0] sum, dif;
  word_t      lg;
  assign sum = {1'b0, a_q} + {1'b0, b_q};
  assign dif = {1'b0, a_q} - {1'b0, b_q};

  always_comb begin
    flags_d = flags_q;
    tgt_d = tgt_q; res_d = res_q; err_d = err_q; halt_d = halt_q; ex_d = ex_q;
    lg = '0;
    if (ctl_i.exec) begin
      tgt_d = TGT_NONE; res_d = '0; err_d = ERR_NONE; halt_d = 1'b0; ex_d = 1'b0;
      if (holds) begin
        unique case (cmd_e'(cmd_q))
          CMD_HALT: halt_d = 1'b1;
          CMD_INT: begin
            if (b_q == W'(VEC_EXIT)) ex_d = 1'b1;
            else if (b_q == W'(VEC_DEC)) begin
              res_d = a_q - W'(1);
              tgt_d = TGT_R0;
              flags_d[FZ] = (a_q == W'(1));
            end
          end
          CMD_MOV: begin res_d = b_q; tgt_d = TGT_DEST; end
          CMD_ADD, CMD_SUB, CMD_CMP: begin
            if (cmd_q == CMD_ADD) begin
              res_d = sum[W-1:0];
              flags_d[FC] = sum[W];
              flags_d[FO] = (a_q[W-1] ^ sum[W-1]) & (b_q[W-1] ^ sum[W-1]);
            end else begin
              res_d = dif[W-1:0];
              flags_d[FC] = dif[W];
              flags_d[FO] = (a_q[W-1] ^ b_q[W-1]) & (a_q[W-1] ^ dif[W-1]);
            end
            flags_d[FZ] = (res_d == '0);
            flags_d[FS] = res_d[W-1];
            if (cmd_q == CMD_CMP) res_d = '0;
            else tgt_d = TGT_DEST;
          end
          CMD_MUL: ;
          CMD_DIV, CMD_IDIV: if (b_q == '0) err_d = ERR_DIV0;
          CMD_AND, CMD_OR, CMD_XOR, CMD_TEST: begin
            if (cmd_q == CMD_OR) lg = a_q | b_q;
            else if (cmd_q == CMD_XOR) lg = a_q ^ b_q;
            else lg = a_q & b_q;
            flags_d = '0;
            flags_d[FZ] = (lg == '0);
            flags_d[FS] = lg[W-1];
            if (cmd_q != CMD_TEST) begin res_d = lg; tgt_d = TGT_DEST; end
          end
          default: err_d = ERR_ILLOP;
        endcase
      end
    end
    if (ctl_i.mul_fin) begin
      res_d = pr_q[W-1:0];
      tgt_d = TGT_DEST;
      flags_d = '0;
      flags_d[FZ] = (pr_q[W-1:0] == '0);
      flags_d[FS] = pr_q[W-1];
      flags_d[FC] = (pr_q[2*W-1:W] != '0);
      if ((a_q[W-1] ^ b_q[W-1]))
        flags_d[FO] = (pm_q[2*W-1:W] != '0) ||
                      (pm_q[W-1:0] > {1'b1, {(W-1){1'b0}}});
      else
        flags_d[FO] = (pm_q[2*W-1:W] != '0) || pm_q[W-1];
    end
    if (ctl_i.div_fin) begin
      res_d = dneg_q ? word_t'(-dq_q) : dq_q;
      tgt_d = TGT_DEST;
      flags_d = '0;
    end
  end

  // multiplier: step k adds one half-by-half partial product per operand set
  logic [1:0]     ia, ib;
  logic [HW-1:0]  xa, xb, ya, yb;
  logic [2*HW-1:0] pp_r, pp_m;
  logic [2*W-1:0]  sh_r, sh_m;
  assign ia = {1'b0, mstep_q[0]};
  assign ib = {1'b0, mstep_q[1]};
  always_comb begin
    xa = mstep_q[0] ? HW'(a_q >> HW) : a_q[HW-1:0];
    xb = mstep_q[1] ? HW'(b_q >> HW) : b_q[HW-1:0];
    ya = mstep_q[0] ? HW'(ma_q >> HW) : ma_q[HW-1:0];
    yb = mstep_q[1] ? HW'(mb_q >> HW) : mb_q[HW-1:0];
  end
  assign pp_r = xa * xb;
  assign pp_m = ya * yb;
  assign sh_r = (2*W)'(pp_r) << ((ia + ib) * HW);
  assign sh_m = (2*W)'(pp_m) << ((ia + ib) * HW);

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      mstep_q <= '0;
      pr_q    <= '0;
      pm_q    <= '0;
      ma_q    <= magn(a_q);
      mb_q    <= magn(b_q);
    end else if (ctl_i.mul_step) begin
      mstep_q <= mstep_q + 2'd1;
      pr_q    <= pr_q + sh_r;
      pm_q    <= pm_q + sh_m;
    end
  end

  // restoring divider, one quotient bit per cycle; idiv works on magnitudes
  logic [W:0] trial;
  word_t      rsh;
  assign rsh   = {dr_q[W-2:0], dd_q[W-1]};
  assign trial = {dr_q[W-1], rsh} - {1'b0, dv_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      dcnt_q <= CW'(W);
      dq_q   <= '0;
      dr_q   <= '0;
      if (cmd_q == CMD_IDIV) begin
        dd_q   <= magn(a_q);
        dv_q   <= magn(b_q);
        dneg_q <= a_q[W-1] ^ b_q[W-1];
      end else begin
        dd_q   <= a_q;
        dv_q   <= b_q;
        dneg_q <= 1'b0;
      end
    end else if (ctl_i.div_step) begin
      dcnt_q <= dcnt_q - CW'(1);
      dd_q   <= {dd_q[W-2:0], 1'b0};
      if (!trial[W]) begin
        dr_q <= trial[W-1:0];
        dq_q <= {dq_q[W-2:0], 1'b1};
      end else begin
        dr_q <= rsh;
        dq_q <= {dq_q[W-2:0], 1'b0};
      end
    end
  end

  // flags and result staging
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) flags_q <= '0;
    else flags_q <= flags_d;
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d; res_q <= res_d; err_q <= err_d;
    halt_q <= halt_d; ex_q <= ex_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      write_target_o <= tgt_q;
      result_value_o <= 64'(res_q);
      flags_out_o    <= flags_q;
      error_code_o   <= err_q;
      halt_request_o <= halt_q;
      exit_request_o <= ex_q;
    end
  end

endmodule

// ----- sv/conditional_alu_with_flags_core.sv -----
// Conditional ALU top level: joins controller and datapath.
// Depends on caf_pkg, caf_ctrl, caf_dp.
// One item at a time. An item is accepted while the unit is idle; most
// operations then pass the states EXEC and OUT, and OUT loads the result
// into the output register and returns to idle for the next item. mul,
// when its condition holds, adds four half-width partial product steps and
// a flag step; div and idiv with a nonzero divisor add DATA_WIDTH quotient
// steps in the restoring divider and a final step. A result still held
// by out_stall_i keeps the unit from returning to idle, which stalls the
// input. Flags persist across items and reset to zero.
module conditional_alu_with_flags_core import caf_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  cmd_i,
  input  logic [3:0]  cond_code_i,
  input  logic [63:0] dest_value_i,
  input  logic [63:0] src_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  write_target_o,
  output logic [63:0] result_value_o,
  output logic [3:0]  flags_out_o,
  output logic [1:0]  error_code_o,
  output logic        halt_request_o,
  output logic        exit_request_o
);

  ctl_t ctl;
  sts_t sts;

  caf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  caf_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .cmd_i, .cond_code_i, .dest_value_i, .src_value_i,
    .write_target_o, .result_value_o, .flags_out_o, .error_code_o,
    .halt_request_o, .exit_request_o
  );

endmodule

// ----- sv/caf_checker.sv -----
// Port-level checker for the conditional ALU, with its bind.
// Depends on caf_pkg and the macros header.
`include "conditional_alu_with_flags_core_macros.svh"
module caf_checker import caf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] write_target_o,
  input logic [1:0] error_code_o,
  input logic       halt_request_o,
  input logic       exit_request_o
);
  `CAF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "no busy")
  `CAF_ASSERT_IMP(a_err_no_write, clk_i, rst_ni, out_valid_o && error_code_o != ERR_NONE, write_target_o == TGT_NONE, "error with write")
  `CAF_ASSERT_IMP(a_one_request, clk_i, rst_ni, out_valid_o, !(halt_request_o && exit_request_o), "halt and exit")
  `CAF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(write_target_o), "item changed")
endmodule

bind conditional_alu_with_flags_core caf_checker u_chk (.*);

// ----- bench/conditional_alu_with_flags_core_tb.sv -----
// Testbench for conditional_alu_with_flags_core: a directed table, then random items.
// Results are checked against a flag-tracking predictor. Depends on caf_pkg and the RTL.
`timescale 1ns / 1ps

module conditional_alu_with_flags_core_tb import caf_pkg::*;;

  // one item in and one result out
  typedef struct {
    logic [3:0]  cmd;
    logic [3:0]  cc;
    logic [63:0] dst;
    logic [63:0] src;
  } alu_op_t;

  typedef struct packed {
    logic [1:0]  tgt;
    logic [63:0] res;
    logic [3:0]  flg;
    logic [1:0]  err;
    logic        halt;
    logic        ex;
  } alu_res_t;

  // a directed row; has_res marks an expectation typed in by hand
  typedef struct {
    alu_op_t  op;
    bit       has_res;
    alu_res_t res;
  } dir_row_t;

  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES = '1;
  localparam longint LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  cmd_i = '0;
  logic [3:0]  cond_code_i = '0;
  logic [63:0] dest_value_i = '0;
  logic [63:0] src_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  write_target_o;
  logic [63:0] result_value_o;
  logic [3:0]  flags_out_o;
  logic [1:0]  error_code_o;
  logic        halt_request_o;
  logic        exit_request_o;

  conditional_alu_with_flags_core u_top (.*);

  // predictor state and expected results
  logic [3:0] model_flags;
  alu_res_t   pending_res[$];
  int         n_err = 0;
  int         n_sent = 0;
  int         n_got = 0;
  bit         long_hold = 1'b0;
  longint     cyc = 0;
  dir_row_t   dir_rows[$];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit cond_ok(logic [3:0] cc, logic [3:0] f);
    bit z, c, o, s;
    z = f[FZ]; c = f[FC]; o = f[FO]; s = f[FS];
    case (cond_e'(cc))
      CC_ALWAYS: return 1;
      CC_Z:      return z;
      CC_NZ:     return !z;
      CC_C:      return c;
      CC_NC:     return !c;
      CC_O:      return o;
      CC_NO:     return !o;
      CC_S:      return s;
      CC_NS:     return !s;
      CC_A:      return !c && !z;
      CC_BE:     return c || z;
      CC_GT:     return !z && (s == o);
      CC_LE:     return z || (s != o);
      CC_GE:     return s == o;
      CC_LT:     return s != o;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [3:0] zs_of(logic [63:0] r);
    logic [3:0] f;
    f = '0;
    f[FZ] = (r == 0);
    f[FS] = r[63];
    return f;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // computes one result and advances the flags
  function automatic alu_res_t exec_alu(alu_op_t op);
    alu_res_t r;
    logic [127:0] prod, mprod;
    logic [63:0] a, b, q;
    logic [3:0] f;
    a = op.dst; b = op.src;
    r = '{default: '0};
    if (cond_ok(op.cc, model_flags)) begin
      case (cmd_e'(op.cmd))
        CMD_HALT: r.halt = 1;
        CMD_INT: begin
          if (b == 64'(VEC_EXIT)) r.ex = 1;
          else if (b == 64'(VEC_DEC)) begin
            r.res = a - 64'd1;
            r.tgt = TGT_R0;
            model_flags[FZ] = (r.res == 0);
          end
        end
        CMD_MOV: begin
          r.res = b; r.tgt = TGT_DEST;
        end
        CMD_ADD: begin
          r.res = a + b;
          f = zs_of(r.res);
          f[FC] = r.res < a;
          f[FO] = (a[63] ^ r.res[63]) & (b[63] ^ r.res[63]);
          model_flags = f; r.tgt = TGT_DEST;
        end
        CMD_SUB, CMD_CMP: begin
          r.res = a - b;
          f = zs_of(r.res);
          f[FC] = a < b;
          f[FO] = (a[63] ^ b[63]) & (a[63] ^ r.res[63]);
          model_flags = f;
          if (op.cmd == CMD_CMP) r.res = 0; else r.tgt = TGT_DEST;
        end
        CMD_MUL: begin
          prod = {64'b0, a} * {64'b0, b};
          r.res = prod[63:0];
          f = zs_of(r.res);
          f[FC] = prod[127:64] != 0;
          mprod = {64'b0, mag(a)} * {64'b0, mag(b)};
          f[FO] = (mprod[127:64] != 0) || (mprod[63:0] != 0 &&
                  ((a[63] ^ b[63]) ? mprod[63:0] > SMIN : mprod[63:0] >= SMIN));
          model_flags = f; r.tgt = TGT_DEST;
        end
        CMD_DIV, CMD_IDIV: begin
          if (b == 0) r.err = ERR_DIV0;
          else begin
            if (op.cmd == CMD_DIV) r.res = a / b;
            else begin
              q = mag(a) / mag(b);
              r.res = (a[63] ^ b[63]) ? -q : q;
            end
            model_flags = '0; r.tgt = TGT_DEST;
          end
        end
        CMD_AND, CMD_OR, CMD_XOR, CMD_TEST: begin
          if (op.cmd == CMD_OR) r.res = a | b;
          else if (op.cmd == CMD_XOR) r.res = a ^ b;
          else r.res = a & b;
          model_flags = zs_of(r.res);
          if (op.cmd == CMD_TEST) r.res = 0; else r.tgt = TGT_DEST;
        end
        default: r.err = ERR_ILLOP;
      endcase
    end
    r.flg = model_flags;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONES;
      2: return SMIN;
      3: return SMIN - 1;
      4: return 64'($urandom_range(0, 300));
      5: return -64'($urandom_range(1, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_op_t rand_op();
    alu_op_t op;
    op.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                          : 4'($urandom_range(0, 12));
    op.cc = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : CC_ALWAYS;
    op.dst = rand64();
    op.src = rand64();
    if (op.cmd == CMD_INT && $urandom_range(0, 2) != 0)
      op.src = 64'($urandom_range(int'(VEC_EXIT), int'(VEC_EXIT) + 2));
    if ((op.cmd == CMD_DIV || op.cmd == CMD_IDIV) && $urandom_range(0, 9) == 0)
      op.src = '0;
    return op;
  endfunction

  // drive one item; the expectation is queued once it is accepted
  task automatic send_op(alu_op_t op, bit has_res, alu_res_t hand);
    alu_res_t r;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= op.cmd;
    cond_code_i <= op.cc;
    dest_value_i <= op.dst;
    src_value_i <= op.src;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = exec_alu(op);
    if (has_res && r != hand) begin
      $display("%0t: table row %0d exp res %h flg %h, predictor res %h flg %h",
               $time, n_sent, hand.res, hand.flg, r.res, r.flg);
      n_err++;
    end
    pending_res.push_back(has_res ? hand : r);
    n_sent++;
  endtask

  // result side: random stalls, one long hold-off when asked
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        hold = 300;
        long_hold = 1'b0;
      end else begin
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // check results against the oldest expectation
  always @(posedge clk_i) begin
    alu_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_got++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, tgt %0d res %h", $time,
                 write_target_o, result_value_o);
        n_err++;
      end else begin
        e = pending_res.pop_front();
        if (e.tgt !== write_target_o || e.res !== result_value_o ||
            e.flg !== flags_out_o || e.err !== error_code_o ||
            e.halt !== halt_request_o || e.ex !== exit_request_o) begin
          $display("%0t: mismatch exp tgt %0d res %h flg %h err %0d halt %0b ex %0b",
                   $time, e.tgt, e.res, e.flg, e.err, e.halt, e.ex);
          $display("%0t:          got tgt %0d res %h flg %h err %0d halt %0b ex %0b",
                   $time, write_target_o, result_value_o, flags_out_o, error_code_o,
                   halt_request_o, exit_request_o);
          n_err++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("conditional_alu_with_flags_core verification failed");
      $finish;
    end
  end

  function automatic dir_row_t row(logic [3:0] c, logic [3:0] cc, logic [63:0] d,
                                   logic [63:0] s);
    dir_row_t x;
    x.op = '{c, cc, d, s};
    x.has_res = 0;
    x.res = '{default: '0};
    return x;
  endfunction

  function automatic dir_row_t hrow(logic [3:0] c, logic [3:0] cc, logic [63:0] d,
                                    logic [63:0] s, logic [1:0] t, logic [63:0] r,
                                    logic [3:0] f, logic [1:0] e, bit h, bit x);
    dir_row_t y;
    y = row(c, cc, d, s);
    y.has_res = 1;
    y.res = '{t, r, f, e, h, x};
    return y;
  endfunction

  initial begin
    alu_op_t op;
    // after reset flags are clear: z fails, nz holds
    dir_rows.push_back(hrow(CMD_MOV, CC_Z, 1, 5, TGT_NONE, 0, 4'h0, ERR_NONE, 0, 0));
    dir_rows.push_back(hrow(CMD_MOV, CC_NZ, 1, ONES, TGT_DEST, ONES, 4'h0, ERR_NONE, 0, 0));
    dir_rows.push_back(hrow(CMD_MOV, CC_NEVER, 1, 5, TGT_NONE, 0, 4'h0, ERR_NONE, 0, 0));
    dir_rows.push_back(hrow(CMD_HALT, CC_ALWAYS, 0, 0, TGT_NONE, 0, 4'h0, ERR_NONE, 1, 0));
    dir_rows.push_back(hrow(CMD_INT, CC_ALWAYS, 0, 64'(VEC_EXIT), TGT_NONE, 0, 4'h0,
                            ERR_NONE, 0, 1));
    dir_rows.push_back(hrow(CMD_ILL13, CC_ALWAYS, 1, 1, TGT_NONE, 0, 4'h0, ERR_ILLOP, 0, 0));
    dir_rows.push_back(hrow(CMD_ILL15, CC_ALWAYS, 1, 1, TGT_NONE, 0, 4'h0, ERR_ILLOP, 0, 0));
    dir_rows.push_back(hrow(CMD_DIV, CC_ALWAYS, 7, 0, TGT_NONE, 0, 4'h0, ERR_DIV0, 0, 0));
    dir_rows.push_back(hrow(CMD_IDIV, CC_ALWAYS, 7, 0, TGT_NONE, 0, 4'h0, ERR_DIV0, 0, 0));
    // signed minimum over minus one wraps
    dir_rows.push_back(hrow(CMD_IDIV, CC_ALWAYS, SMIN, ONES, TGT_DEST, SMIN, 4'h0,
                            ERR_NONE, 0, 0));
    dir_rows.push_back(hrow(CMD_ADD, CC_ALWAYS, ONES, 1, TGT_DEST, 0, 4'h3, ERR_NONE, 0, 0));
    dir_rows.push_back(row(CMD_ADD, CC_ALWAYS, SMIN - 1, 1));
    dir_rows.push_back(row(CMD_SUB, CC_ALWAYS, 0, 1));
    dir_rows.push_back(row(CMD_CMP, CC_ALWAYS, SMIN, 1));
    dir_rows.push_back(row(CMD_IDIV, CC_ALWAYS, -64'd7, 2));
    dir_rows.push_back(row(CMD_MUL, CC_ALWAYS, ONES, ONES));
    dir_rows.push_back(row(CMD_MUL, CC_ALWAYS, SMIN, 1));
    dir_rows.push_back(row(CMD_DIV, CC_ALWAYS, ONES, 3));
    dir_rows.push_back(row(CMD_AND, CC_ALWAYS, ONES, SMIN));
    dir_rows.push_back(row(CMD_OR, CC_ALWAYS, 0, 0));
    dir_rows.push_back(row(CMD_XOR, CC_ALWAYS, ONES, 1));
    dir_rows.push_back(row(CMD_TEST, CC_ALWAYS, 0, ONES));
    // decrement of register zero to zero, then a conditional decrement and another vector
    dir_rows.push_back(row(CMD_INT, CC_ALWAYS, 1, 64'(VEC_DEC)));
    dir_rows.push_back(row(CMD_INT, CC_GE, 0, 64'(VEC_DEC)));
    dir_rows.push_back(row(CMD_INT, CC_ALWAYS, 5, 64'h82));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    model_flags = '0;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].has_res, dir_rows[i].res);
    in_valid_i <= 1'b0;

    // sender pauses until everything has drained
    while (pending_res.size() != 0) @(posedge clk_i);

    for (int i = 0; i < 625; i++) begin
      if (i == 200) long_hold = 1'b1;
      op = rand_op();
      send_op(op, 0, '{default: '0});
    end
    in_valid_i <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Ran %0d items (directed table, then random ops and conditions), %0d results.",
             n_sent, n_got);
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("conditional_alu_with_flags_core verification clean");
    end else begin
      $display("conditional_alu_with_flags_core verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/caf_pkg.sv
sv/caf_ctrl.sv
sv/caf_dp.sv
sv/conditional_alu_with_flags_core.sv
sv/caf_checker.sv
bench/conditional_alu_with_flags_core_tb.sv
